[design/atrem_pkg.sv]
// Package for the audio tremolo: sizes, register codes, queue word type
// and the quarter-wave sine ROM contents built at elaboration.
// No dependencies.
package atrem_pkg;

	localparam int SINE_DEPTH  = 1024;
	localparam int PHASE_BITS  = 32;
	localparam int IDX_W       = $clog2(SINE_DEPTH + 1);
	localparam int REST_W      = PHASE_BITS - 2;
	localparam int SAMPLE_W    = 16;
	localparam int DEPTH_W     = 16;
	localparam int STEP_W      = 32;
	localparam int GAIN_W      = 16;
	localparam int ROM_W       = 15;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 32;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [DEPTH_W-1:0] DEPTH_FULL  = 16'd32768;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET = 16'd32768;
	localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd894785;
	localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MOD_DEPTH  = 1'b0,
		REG_PHASE_STEP = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic [IDX_W-1:0]           idx;
		logic                       neg;
	} atrem_word_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	typedef logic [ROM_W-1:0] sine_rom_t [SINE_DEPTH+1];

	function automatic sine_rom_t build_sine_rom();
		sine_rom_t   t;
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] v;
		for (int i = 0; i < SINE_DEPTH; i++) begin
			x = (HALF_PI_Q30 * 64'(i)) / SINE_DEPTH;
			term = x;
			sum = x;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 6;
			sum = sum - term;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 20;
			sum = sum + term;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 42;
			sum = sum - term;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 72;
			sum = sum + term;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 110;
			sum = sum - term;
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / 156;
			sum = sum + term;
			v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			t[i] = v[ROM_W-1:0];
		end
		t[SINE_DEPTH] = 15'd32767;
		return t;
	endfunction

endpackage

[design/atrem_in_if.sv]
// Input channel of the audio tremolo: valid/ready and one input sample.
// Depends on atrem_pkg.
interface atrem_in_if import atrem_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

[design/atrem_out_if.sv]
// Output channel of the audio tremolo: valid/ready and one result sample.
// Depends on atrem_pkg.
interface atrem_out_if import atrem_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

[design/atrem_queue.sv]
// Short queue between the front and back parts of the tremolo.
// Depends on atrem_pkg.
module atrem_queue import atrem_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  atrem_word_t push_word,
	input  logic        pop,
	output atrem_word_t head,
	output queue_stat_t stat
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	atrem_word_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == CNT_W'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[design/atrem_front.sv]
// Front part of the tremolo: accepts samples, holds the phase accumulator
// and turns the phase into a quarter-wave table index and a sign.
// Depends on atrem_pkg and atrem_in_if.
module atrem_front import atrem_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [STEP_W-1:0] phase_step,
	atrem_in_if.sink          in_ch,
	input  queue_stat_t       q_stat,
	output logic              push,
	output atrem_word_t       push_word
);

	localparam int KPROD_W = REST_W + IDX_W;

	logic [PHASE_BITS-1:0] phase_q;
	logic [REST_W-1:0]     rest;
	logic [KPROD_W-1:0]    kprod;
	logic [IDX_W-1:0]      k;

	assign in_ch.ready = !q_stat.full;
	assign push        = in_ch.valid && !q_stat.full;

	assign rest  = phase_q[REST_W-1:0];
	assign kprod = KPROD_W'(rest) * KPROD_W'(SINE_DEPTH);
	assign k     = kprod[REST_W +: IDX_W];

	always_comb begin
		push_word.sample = in_ch.sample_in;
		push_word.neg    = phase_q[PHASE_BITS-1];
		if (phase_q[PHASE_BITS-2]) begin
			push_word.idx = IDX_W'(SINE_DEPTH) - k;
		end else begin
			push_word.idx = k;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
		end else if (push) begin
			phase_q <= phase_q + PHASE_BITS'(phase_step);
		end
	end

endmodule

[design/atrem_back.sv]
// Back part of the tremolo: sine ROM read, gain and scaling on one shared
// multiplier, rounding, saturation and the output register.
// Depends on atrem_pkg and atrem_out_if.
module atrem_back import atrem_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [DEPTH_W-1:0] mod_depth,
	input  queue_stat_t        q_stat,
	input  atrem_word_t        head,
	output logic               pop,
	atrem_out_if.source        out_ch
);

	localparam sine_rom_t SINE_ROM = build_sine_rom();
	localparam int        MUL_W    = 17;
	localparam int        PROD_W   = 2 * MUL_W;
	localparam int        NUM_W    = 34;

	typedef enum logic [2:0] {
		B_FETCH,
		B_GMUL,
		B_GAIN,
		B_XMUL,
		B_ROUND
	} back_state_t;

	back_state_t                state_q;
	logic [ROM_W-1:0]           rom_q;
	logic                       neg_q;
	logic signed [SAMPLE_W-1:0] x_q;
	logic [GAIN_W-1:0]          gain_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic                       out_valid_q;
	logic signed [SAMPLE_W-1:0] out_q;

	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic [NUM_W-1:0]         num_base;
	logic [NUM_W-1:0]         num;
	logic [NUM_W-1:0]         num_rnd;
	logic                     p_neg;
	logic [PROD_W-1:0]        mag;
	logic [PROD_W-1:0]        mag_rnd;
	logic [16:0]              r;
	logic signed [SAMPLE_W-1:0] res;
	logic                     out_free;

	assign out_free = !out_valid_q || out_ch.ready;
	assign pop = !q_stat.empty && ((state_q == B_FETCH) || ((state_q == B_ROUND) && out_free));

	always_comb begin
		if (state_q == B_XMUL) begin
			mul_a = MUL_W'(x_q);
			mul_b = signed'({1'b0, gain_q});
		end else begin
			mul_a = signed'({1'b0, mod_depth});
			mul_b = signed'({2'b00, rom_q});
		end
	end

	assign num_base = NUM_W'(34'h0_8000_0000) - (NUM_W'(mod_depth) << 15);
	assign num      = neg_q ? num_base - NUM_W'(prod_q[30:0]) : num_base + NUM_W'(prod_q[30:0]);
	assign num_rnd  = num + NUM_W'(32768);

	assign p_neg   = prod_q[PROD_W-1];
	assign mag     = p_neg ? PROD_W'(-prod_q) : PROD_W'(prod_q);
	assign mag_rnd = mag + PROD_W'(16384);
	assign r       = mag_rnd[31:15];

	always_comb begin
		if (p_neg) begin
			res = signed'(-r[SAMPLE_W-1:0]);
		end else if (r > 17'd32767) begin
			res = 16'sd32767;
		end else begin
			res = signed'(r[SAMPLE_W-1:0]);
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.sample_out = out_q;

	always_ff @(posedge clk) begin
		if (pop) begin
			rom_q <= SINE_ROM[head.idx];
			neg_q <= head.neg;
			x_q   <= head.sample;
		end
		if (state_q == B_GMUL || state_q == B_XMUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == B_GAIN) begin
			gain_q <= num_rnd[31:16];
		end
		if (state_q == B_ROUND && out_free) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_FETCH;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == B_ROUND && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				B_FETCH: begin
					if (pop) begin
						state_q <= B_GMUL;
					end
				end
				B_GMUL: begin
					state_q <= B_GAIN;
				end
				B_GAIN: begin
					state_q <= B_XMUL;
				end
				B_XMUL: begin
					state_q <= B_ROUND;
				end
				B_ROUND: begin
					if (out_free) begin
						state_q <= pop ? B_GMUL : B_FETCH;
					end
				end
				default: begin
					state_q <= B_FETCH;
				end
			endcase
		end
	end

endmodule

[design/audio_tremolo.sv]
// Sine-LFO tremolo on a 16-bit audio stream. Every accepted word gives exactly one
// result word, scaled by 1 - depth/2 + (depth/2)*sin(phase) with a 32-bit phase that
// steps by phase_step after each word. Configuration is to be written through cfg_we,
// cfg_index and cfg_data only while the block is idle; the block itself does not
// enforce this. The back part shares one 17x17 multiplier between the gain and the
// scaling step and takes a new word from the queue only as it finishes the last one;
// a two-word queue decouples input acceptance from that work.
// Depends on atrem_pkg, atrem_in_if, atrem_out_if, atrem_queue, atrem_front, atrem_back.
module audio_tremolo import atrem_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	atrem_in_if.sink              in_ch,
	atrem_out_if.source           out_ch
);

	logic [DEPTH_W-1:0] depth_q;
	logic [STEP_W-1:0]  step_q;
	logic [DEPTH_W-1:0] depth_wr;
	queue_stat_t        q_stat;
	atrem_word_t        push_word;
	atrem_word_t        head;
	logic               push;
	logic               pop;

	assign depth_wr = (cfg_data[DEPTH_W-1:0] > DEPTH_FULL) ? DEPTH_FULL : cfg_data[DEPTH_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_RESET;
			step_q  <= STEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_MOD_DEPTH: begin
					depth_q <= depth_wr;
				end
				REG_PHASE_STEP: begin
					step_q <= cfg_data[STEP_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	atrem_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.phase_step (step_q),
		.in_ch      (in_ch),
		.q_stat     (q_stat),
		.push       (push),
		.push_word  (push_word)
	);

	atrem_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_word (push_word),
		.pop       (pop),
		.head      (head),
		.stat      (q_stat)
	);

	atrem_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mod_depth (depth_q),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_ch    (out_ch)
	);

endmodule

[design/atrem_checker.sv]
// Port-level checks for the audio tremolo, bound to the top level.
// Depends on atrem_pkg and audio_tremolo.
module atrem_checker import atrem_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic signed [SAMPLE_W-1:0] sample_out
);

	localparam int MAX_OPEN = QUEUE_DEPTH + 2;
	localparam int OPEN_W   = $clog2(MAX_OPEN + 2);

	logic [OPEN_W-1:0] open_q;
	logic              in_acc;
	logic              out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (in_acc && !out_acc) begin
			open_q <= open_q + 1'b1;
		end else if (out_acc && !in_acc) begin
			open_q <= open_q - 1'b1;
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("result word changed while stalled");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> open_q != '0)
		else $error("result word without an accepted input word");

	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		open_q <= OPEN_W'(MAX_OPEN))
		else $error("more words in flight than the block can hold");

endmodule

bind audio_tremolo atrem_checker u_atrem_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);
